/* sv/weighted_random_pick_order_assert.svh */
// assertion macros for the weighted random pick order block
// used by the top level only, no other dependencies
`ifndef WEIGHTED_RANDOM_PICK_ORDER_ASSERT_SVH
`define WEIGHTED_RANDOM_PICK_ORDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define WRP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define WRP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define WRP_ASSERT(label, clk, rstn, prop, msg)
`define WRP_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* sv/wrp_pkg.sv */
// shared constants, types and sequencer states for the weighted random pick order block
// no dependencies
package wrp_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int DRAW_BITS   = 31;
    localparam int WEIGHT_W    = 16;
    localparam int RAND_W      = 31;
    localparam int OUT_IDX_W   = 5;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    // wide enough for the full weight total plus one
    localparam int SUM_W       = $clog2(MAX_ENTRIES * (2 ** WEIGHT_W - 1) + 2);
    localparam int PROD_W      = DRAW_BITS + SUM_W;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } wrp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_WALK,
        ST_DONE
    } wrp_state_t;

    typedef struct packed {
        logic clear;
        logic add;
        logic scale;
    } wrp_dp_ctrl_t;

endpackage

/* sv/wrp_ram.sv */
// generic single write port ram with registered read
// no dependencies
module wrp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/wrp_datapath.sv */
// shared accumulate, scale and compare unit for both passes of a pick
// depends on wrp_pkg
module wrp_datapath (
    input  logic                              aclk,
    input  wrp_pkg::wrp_dp_ctrl_t             ctrl,
    input  logic [wrp_pkg::WEIGHT_W-1:0]      weight,
    input  logic [wrp_pkg::DRAW_BITS-1:0]     draw,
    output logic                              hit
);

    logic [wrp_pkg::SUM_W-1:0]  acc_reg, acc_next;
    logic [wrp_pkg::SUM_W-1:0]  scaled_reg, scaled_next;
    logic [wrp_pkg::SUM_W-1:0]  sum;
    logic [wrp_pkg::SUM_W-1:0]  total_plus;
    logic [wrp_pkg::PROD_W-1:0] prod;

    assign sum        = acc_reg + wrp_pkg::SUM_W'(weight);
    assign total_plus = acc_reg + wrp_pkg::SUM_W'(1);
    assign prod       = wrp_pkg::PROD_W'(draw) * wrp_pkg::PROD_W'(total_plus);
    assign hit        = (sum >= scaled_reg);

    always_comb begin
        acc_next    = acc_reg;
        scaled_next = scaled_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.add) begin
            acc_next = sum;
        end
        // floor(r * (T + 1) / 2^DRAW_BITS)
        if (ctrl.scale) begin
            scaled_next = prod[wrp_pkg::PROD_W-1:wrp_pkg::DRAW_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        scaled_reg <= scaled_next;
    end

endmodule

/* sv/weighted_random_pick_order.sv */
// Weighted random pick order, top level.
// Input channel s_*: one beat carries op, weight and random_draw. Op append
// stores a weight at the next free entry (ignored when full), op clear empties
// the table, op pick chooses one unchosen entry by weighted draw and marks it.
// Only a pick gives a result beat on m_*: found and entry_index (found low
// with index zero when no unchosen entry is left).
// Append and clear are handled as soon as they are accepted. A pick runs one
// pass that totals the unchosen weights, a step that scales the draw, a second
// pass that walks the running sum, and a step that loads the result register.
// Both passes read the weight ram once per cycle and share one accumulator, so
// the ram read port and the accumulator set the pace of a pick.
// s_ready is high only while no pick is at work; a result waiting in the
// output register does not hold off new beats, but a pick that finishes while
// the receiver stalls waits until the output register is free.
// Reset (aresetn low, synchronous) empties the table and clears all marks
// and the output valid; stored weights are not cleared.
// depends on wrp_pkg, wrp_ram, wrp_datapath and the assertion macro header
`include "weighted_random_pick_order_assert.svh"
module weighted_random_pick_order (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_op,
    input  logic [wrp_pkg::WEIGHT_W-1:0]      s_weight,
    input  logic [wrp_pkg::RAND_W-1:0]        s_random_draw,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_found,
    output logic [wrp_pkg::OUT_IDX_W-1:0]     m_entry_index
);

    wrp_pkg::wrp_state_t state_reg, state_next;

    logic [wrp_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [wrp_pkg::MAX_ENTRIES-1:0] marks_reg, marks_next;
    logic [wrp_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic                            rd_chosen_reg, rd_chosen_next;
    logic [wrp_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                            any_reg, any_next;
    logic [wrp_pkg::DRAW_BITS-1:0]   draw_reg, draw_next;
    logic                            found_pend_reg, found_pend_next;
    logic [wrp_pkg::IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            m_found_reg, m_found_next;
    logic [wrp_pkg::OUT_IDX_W-1:0]   m_entry_index_reg, m_entry_index_next;

    logic                            accept;
    logic                            start_pick;
    logic                            ram_we;
    logic                            issue;
    logic                            hit_ok;
    logic                            dp_hit;
    logic                            out_load;
    logic                            not_full;
    logic [wrp_pkg::WEIGHT_W-1:0]    rd_weight;
    wrp_pkg::wrp_dp_ctrl_t           dp_ctrl;

    assign s_ready    = (state_reg == wrp_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign start_pick = accept && (s_op == wrp_pkg::OP_PICK);
    assign not_full   = (count_reg < wrp_pkg::CNT_W'(wrp_pkg::MAX_ENTRIES));
    assign ram_we     = accept && (s_op == wrp_pkg::OP_APPEND) && not_full;
    assign issue      = ((state_reg == wrp_pkg::ST_SUM) || (state_reg == wrp_pkg::ST_WALK))
                        && (idx_reg < count_reg);
    assign hit_ok     = (state_reg == wrp_pkg::ST_WALK) && rd_vld_reg && !rd_chosen_reg
                        && dp_hit;
    assign out_load   = (state_reg == wrp_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    wrp_ram #(
        .WIDTH (wrp_pkg::WEIGHT_W),
        .DEPTH (wrp_pkg::MAX_ENTRIES)
    ) u_weight_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[wrp_pkg::IDX_W-1:0]),
        .wr_data (s_weight),
        .rd_addr (idx_reg[wrp_pkg::IDX_W-1:0]),
        .rd_data (rd_weight)
    );

    wrp_datapath u_datapath (
        .aclk   (aclk),
        .ctrl   (dp_ctrl),
        .weight (rd_weight),
        .draw   (draw_reg),
        .hit    (dp_hit)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wrp_pkg::ST_IDLE: begin
                if (start_pick) begin
                    state_next = wrp_pkg::ST_SUM;
                end
            end
            wrp_pkg::ST_SUM: begin
                if (idx_reg == count_reg) begin
                    state_next = wrp_pkg::ST_SCALE;
                end
            end
            wrp_pkg::ST_SCALE: begin
                state_next = wrp_pkg::ST_WALK;
            end
            wrp_pkg::ST_WALK: begin
                if (hit_ok || (idx_reg == count_reg)) begin
                    state_next = wrp_pkg::ST_DONE;
                end
            end
            wrp_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = wrp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wrp_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and register updates
    always_comb begin
        count_next         = count_reg;
        marks_next         = marks_reg;
        idx_next           = idx_reg;
        any_next           = any_reg;
        draw_next          = draw_reg;
        found_pend_next    = found_pend_reg;
        hit_idx_next       = hit_idx_reg;
        m_valid_next       = m_valid_reg;
        m_found_next       = m_found_reg;
        m_entry_index_next = m_entry_index_reg;
        rd_vld_next        = issue;
        rd_chosen_next     = marks_reg[idx_reg[wrp_pkg::IDX_W-1:0]];
        rd_idx_next        = idx_reg[wrp_pkg::IDX_W-1:0];

        dp_ctrl.clear = start_pick || (state_reg == wrp_pkg::ST_SCALE);
        dp_ctrl.add   = ((state_reg == wrp_pkg::ST_SUM) || (state_reg == wrp_pkg::ST_WALK))
                        && rd_vld_reg && !rd_chosen_reg;
        dp_ctrl.scale = (state_reg == wrp_pkg::ST_SCALE);

        if (accept) begin
            case (s_op)
                wrp_pkg::OP_APPEND: begin
                    if (not_full) begin
                        marks_next[count_reg[wrp_pkg::IDX_W-1:0]] = 1'b0;
                        count_next = count_reg + wrp_pkg::CNT_W'(1);
                    end
                end
                wrp_pkg::OP_PICK: begin
                    idx_next        = '0;
                    any_next        = 1'b0;
                    found_pend_next = 1'b0;
                    hit_idx_next    = '0;
                    draw_next       = wrp_pkg::DRAW_BITS'(s_random_draw);
                end
                wrp_pkg::OP_CLEAR: begin
                    count_next = '0;
                    marks_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (state_reg == wrp_pkg::ST_SCALE) begin
            idx_next = '0;
        end else if (issue) begin
            idx_next = idx_reg + wrp_pkg::CNT_W'(1);
        end

        if ((state_reg == wrp_pkg::ST_SUM) && dp_ctrl.add) begin
            any_next = 1'b1;
        end

        if (hit_ok) begin
            marks_next[rd_idx_reg] = 1'b1;
            found_pend_next        = 1'b1;
            hit_idx_next           = rd_idx_reg;
        end

        if (out_load) begin
            m_valid_next       = 1'b1;
            m_found_next       = found_pend_reg;
            m_entry_index_next = wrp_pkg::OUT_IDX_W'(hit_idx_reg);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wrp_pkg::ST_IDLE;
            count_reg   <= '0;
            marks_reg   <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            marks_reg   <= marks_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_chosen_reg     <= rd_chosen_next;
        rd_idx_reg        <= rd_idx_next;
        any_reg           <= any_next;
        draw_reg          <= draw_next;
        found_pend_reg    <= found_pend_next;
        hit_idx_reg       <= hit_idx_next;
        m_found_reg       <= m_found_next;
        m_entry_index_reg <= m_entry_index_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_entry_index = m_entry_index_reg;

    `WRP_ASSERT(a_count_bound, aclk, aresetn, count_reg <= wrp_pkg::CNT_W'(wrp_pkg::MAX_ENTRIES), "entry count beyond table depth")
    `WRP_ASSERT(a_marks_loaded, aclk, aresetn, $countones(marks_reg) <= int'(count_reg), "chosen mark on an entry that is not loaded")
    `WRP_ASSERT_IMP(a_miss_only_empty, aclk, aresetn, (state_reg == wrp_pkg::ST_DONE) && !found_pend_reg, !any_reg, "pick missed although unchosen entries remain")
    `WRP_ASSERT_IMP(a_idle_no_read, aclk, aresetn, state_reg == wrp_pkg::ST_IDLE, !rd_vld_reg, "weight read still in flight while idle")

endmodule
